@@ design/assert_macros.svh @@
// assertion macros used by the command parser controller
// no dependencies; take in with `include after the default_nettype line
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with async active-low reset, fixed message
`define SACP_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("sacp assertion failed");

// same, with a caller supplied message string
`define SACP_ASSERT_MSG(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error(msg);

`endif

@@ design/sacp_pkg.sv @@
// types, character codes and the duty table of the serial actuator command parser
// no dependencies; used by the controller, the datapath and the top level
`default_nettype none

package sacp_pkg;

	localparam int MAG_LIMIT = 100;
	localparam int DUTY_FULL = 255;
	localparam int MAG_W     = 7;
	localparam int POS_W     = 3;

	localparam logic [MAG_W-1:0] MAG_MAX = 7'd100;
	localparam logic [MAG_W-1:0] MAG_SAT = 7'd101;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_C     = "c";
	localparam logic [7:0] CH_E     = "e";
	localparam logic [7:0] CH_F     = "f";
	localparam logic [7:0] CH_M     = "m";
	localparam logic [7:0] CH_N     = "n";
	localparam logic [7:0] CH_O     = "o";
	localparam logic [7:0] CH_P     = "p";
	localparam logic [7:0] CH_R     = "r";
	localparam logic [7:0] CH_S     = "s";
	localparam logic [7:0] CH_T     = "t";
	localparam logic [7:0] CH_V     = "v";

	typedef enum logic [1:0] {
		WORD_COMP,
		WORD_VENT,
		WORD_SERVO
	} word_t;

	typedef enum logic [2:0] {
		ACT_COMP_RELAY = 3'd0,
		ACT_VENT_RELAY = 3'd1,
		ACT_VENT_DUTY  = 3'd2,
		ACT_SERVO_DUTY = 3'd3,
		ACT_UNKNOWN    = 3'd4
	} action_t;

	typedef struct packed {
		logic    store;
		logic    scan_start;
		logic    scan_run;
		logic    clear_len;
		logic    word_set;
		word_t   word;
		logic    pos_inc;
		logic    mag_digit;
		logic    set_neg;
		logic    emit;
		action_t action;
		logic    relay_level;
		logic    use_duty;
	} dp_cmd_t;

	typedef struct packed {
		logic  ch_valid;
		logic  c_zero;
		logic  c_blank;
		logic  c_ws;
		logic  c_digit;
		logic  c_plus;
		logic  c_minus;
		logic  c_o;
		logic  c_n;
		logic  c_f;
		logic  lead_found;
		word_t lead_word;
		logic  word_hit;
		logic  word_last;
		word_t word;
		logic  rx_eol;
		logic  line_empty;
	} dp_sts_t;

	typedef logic [7:0] duty_tbl_t [0:MAG_LIMIT];

	function automatic duty_tbl_t build_duty_tbl();
		duty_tbl_t t;
		for (int i = 0; i <= MAG_LIMIT; i++) begin
			t[i] = 8'((i * DUTY_FULL) / MAG_LIMIT);
		end
		return t;
	endfunction

	localparam duty_tbl_t DUTY_TBL = build_duty_tbl();

	// expected character of a command word at a position
	function automatic logic [7:0] word_char(word_t w, logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = CH_NUL;
		case (w)
			WORD_COMP: begin
				case (pos)
					3'd0: c = CH_C;
					3'd1: c = CH_O;
					3'd2: c = CH_M;
					3'd3: c = CH_P;
					default: c = CH_NUL;
				endcase
			end
			WORD_VENT: begin
				case (pos)
					3'd0: c = CH_V;
					3'd1: c = CH_E;
					3'd2: c = CH_N;
					3'd3: c = CH_T;
					default: c = CH_NUL;
				endcase
			end
			WORD_SERVO: begin
				case (pos)
					3'd0: c = CH_S;
					3'd1: c = CH_E;
					3'd2: c = CH_R;
					3'd3: c = CH_V;
					3'd4: c = CH_O;
					default: c = CH_NUL;
				endcase
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [POS_W-1:0] word_last_pos(word_t w);
		logic [POS_W-1:0] p;
		case (w)
			WORD_SERVO: p = 3'd4;
			default:    p = 3'd3;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

@@ design/sacp_in_if.sv @@
// input channel of the command parser: one received serial byte per item
// no dependencies
`default_nettype none

interface sacp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ design/sacp_out_if.sv @@
// result channel of the command parser: one actuator command per item
// no dependencies
`default_nettype none

interface sacp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic       relay_level;
	logic [7:0] duty;

	modport source (output valid, output action, output relay_level, output duty, input ready);
	modport sink (input valid, input action, input relay_level, input duty, output ready);
endinterface

`default_nettype wire

@@ design/sacp_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module sacp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/sacp_dp.sv @@
// datapath of the command parser: line store, length, scan pointer, number and result
// depends on sacp_pkg and sacp_ram
`default_nettype none

module sacp_dp #(
	parameter int LINE_BYTES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         rx_byte,
	input  wire sacp_pkg::dp_cmd_t  cmd,
	output      sacp_pkg::dp_sts_t  sts,
	output      logic [2:0]         action,
	output      logic               relay_level,
	output      logic [7:0]         duty
);

	localparam int AW = $clog2(LINE_BYTES);
	localparam logic [AW-1:0] LEN_MAX = AW'(LINE_BYTES - 1);

	logic [AW-1:0]                  len_q;
	logic [AW-1:0]                  rd_idx_q;
	logic [AW-1:0]                  idx_s1;
	logic                           ch_valid_s1;
	logic [7:0]                     rdata_s1;
	sacp_pkg::word_t                word_q;
	logic [sacp_pkg::POS_W-1:0]     pos_q;
	logic [sacp_pkg::MAG_W-1:0]     mag_q;
	logic                           neg_q;
	logic [2:0]                     action_q;
	logic                           relay_q;
	logic [7:0]                     duty_q;

	logic                           wr_en;
	logic [7:0]                     ch;
	logic [9:0]                     mag_acc;
	logic [sacp_pkg::MAG_W-1:0]     mag_next;
	logic [sacp_pkg::MAG_W-1:0]     mag_eff;

	assign wr_en = cmd.store && (len_q < LEN_MAX);

	sacp_ram #(
		.WIDTH (8),
		.DEPTH (LINE_BYTES)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (len_q),
		.wdata (rx_byte),
		.re    (cmd.scan_run),
		.raddr (rd_idx_q),
		.rdata (rdata_s1)
	);

	// past the stored length the line reads as a terminating zero
	assign ch = (idx_s1 < len_q) ? rdata_s1 : sacp_pkg::CH_NUL;

	always_comb begin
		sts.ch_valid   = ch_valid_s1;
		sts.c_zero     = (ch == sacp_pkg::CH_NUL);
		sts.c_blank    = (ch == sacp_pkg::CH_SPACE) || (ch == sacp_pkg::CH_TAB);
		sts.c_ws       = (ch == sacp_pkg::CH_SPACE) ||
		                 ((ch >= sacp_pkg::CH_TAB) && (ch <= sacp_pkg::CH_CR));
		sts.c_digit    = (ch >= sacp_pkg::CH_ZERO) && (ch <= sacp_pkg::CH_NINE);
		sts.c_plus     = (ch == sacp_pkg::CH_PLUS);
		sts.c_minus    = (ch == sacp_pkg::CH_MINUS);
		sts.c_o        = (ch == sacp_pkg::CH_O);
		sts.c_n        = (ch == sacp_pkg::CH_N);
		sts.c_f        = (ch == sacp_pkg::CH_F);
		sts.lead_found = 1'b1;
		if (ch == sacp_pkg::CH_C) begin
			sts.lead_word = sacp_pkg::WORD_COMP;
		end else if (ch == sacp_pkg::CH_V) begin
			sts.lead_word = sacp_pkg::WORD_VENT;
		end else begin
			sts.lead_word  = sacp_pkg::WORD_SERVO;
			sts.lead_found = (ch == sacp_pkg::CH_S);
		end
		sts.word_hit   = (ch == sacp_pkg::word_char(word_q, pos_q));
		sts.word_last  = (pos_q == sacp_pkg::word_last_pos(word_q));
		sts.word       = word_q;
		sts.rx_eol     = (rx_byte == sacp_pkg::CH_CR) || (rx_byte == sacp_pkg::CH_LF);
		sts.line_empty = (len_q == '0);
	end

	// decimal accumulate, sticks at one past the limit once exceeded
	always_comb begin
		mag_acc = 10'(mag_q) * 10'd10 + 10'(ch - sacp_pkg::CH_ZERO);
		if (mag_acc > 10'(sacp_pkg::MAG_MAX)) begin
			mag_next = sacp_pkg::MAG_SAT;
		end else begin
			mag_next = mag_acc[sacp_pkg::MAG_W-1:0];
		end
		if (neg_q) begin
			mag_eff = '0;
		end else if (mag_q > sacp_pkg::MAG_MAX) begin
			mag_eff = sacp_pkg::MAG_MAX;
		end else begin
			mag_eff = mag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			rd_idx_q    <= '0;
			ch_valid_s1 <= 1'b0;
			idx_s1      <= '0;
			word_q      <= sacp_pkg::WORD_COMP;
			pos_q       <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
		end else begin
			ch_valid_s1 <= cmd.scan_run;
			if (wr_en) begin
				len_q <= len_q + AW'(1);
			end else if (cmd.clear_len) begin
				len_q <= '0;
			end
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				mag_q    <= '0;
				neg_q    <= 1'b0;
			end else begin
				if (cmd.scan_run) begin
					idx_s1 <= rd_idx_q;
					if (rd_idx_q < LEN_MAX) begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				if (cmd.mag_digit) begin
					mag_q <= mag_next;
				end
				if (cmd.set_neg) begin
					neg_q <= 1'b1;
				end
			end
			if (cmd.word_set) begin
				word_q <= cmd.word;
				pos_q  <= 3'd1;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			action_q <= cmd.action;
			relay_q  <= cmd.relay_level;
			duty_q   <= cmd.use_duty ? sacp_pkg::DUTY_TBL[mag_eff] : 8'h00;
		end
	end

	assign action      = action_q;
	assign relay_level = relay_q;
	assign duty        = duty_q;

endmodule

`default_nettype wire

@@ design/sacp_ctrl.sv @@
// controller of the command parser: line collection and the one-pass parse of a line
// depends on sacp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sacp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output      logic              rx_ready,
	output      logic              out_valid,
	input  wire logic              out_ready,
	input  wire sacp_pkg::dp_sts_t sts,
	output      sacp_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAD,
		ST_WORD,
		ST_SKIPW,
		ST_SKIPB,
		ST_SW_O,
		ST_SW_OF,
		ST_DWS,
		ST_DDIG
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   rx_acc;

	// a line end waits until the previous result has been taken
	assign rx_ready  = (state_q == ST_IDLE) && (!sts.rx_eol || !out_valid_q);
	assign rx_acc    = rx_valid && rx_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		logic              go_arg;
		logic              go_duty;
		logic              done;
		logic              sw_fail;
		sacp_pkg::action_t relay_act;
		sacp_pkg::action_t duty_act;

		go_arg  = 1'b0;
		go_duty = 1'b0;
		done    = 1'b0;
		sw_fail = 1'b0;
		relay_act = (sts.word == sacp_pkg::WORD_COMP) ? sacp_pkg::ACT_COMP_RELAY
		                                              : sacp_pkg::ACT_VENT_RELAY;
		duty_act  = (sts.word == sacp_pkg::WORD_SERVO) ? sacp_pkg::ACT_SERVO_DUTY
		                                               : sacp_pkg::ACT_VENT_DUTY;
		state_d = state_q;
		cmd     = '0;

		case (state_q)
			ST_IDLE: begin
				if (rx_acc) begin
					if (!sts.rx_eol) begin
						cmd.store = 1'b1;
					end else if (!sts.line_empty) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_LEAD;
					end
				end
			end
			ST_LEAD: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid && !sts.c_blank) begin
					if (sts.c_zero) begin
						done = 1'b1;
					end else if (sts.lead_found) begin
						cmd.word_set = 1'b1;
						cmd.word     = sts.lead_word;
						state_d      = ST_WORD;
					end else begin
						cmd.emit   = 1'b1;
						cmd.action = sacp_pkg::ACT_UNKNOWN;
						done       = 1'b1;
					end
				end
			end
			ST_WORD: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid) begin
					if (!sts.word_hit) begin
						cmd.emit   = 1'b1;
						cmd.action = sacp_pkg::ACT_UNKNOWN;
						done       = 1'b1;
					end else if (sts.word_last) begin
						state_d = ST_SKIPW;
					end else begin
						cmd.pos_inc = 1'b1;
					end
				end
			end
			ST_SKIPW: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid) begin
					if (sts.c_blank) begin
						state_d = ST_SKIPB;
					end else if (sts.c_zero) begin
						go_arg = 1'b1;
					end
				end
			end
			ST_SKIPB: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid && !sts.c_blank) begin
					go_arg = 1'b1;
				end
			end
			ST_SW_O: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid) begin
					if (sts.c_n) begin
						cmd.emit        = 1'b1;
						cmd.action      = relay_act;
						cmd.relay_level = 1'b1;
						done            = 1'b1;
					end else if (sts.c_f) begin
						state_d = ST_SW_OF;
					end else begin
						sw_fail = 1'b1;
					end
				end
			end
			ST_SW_OF: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid) begin
					if (sts.c_f) begin
						cmd.emit   = 1'b1;
						cmd.action = relay_act;
						done       = 1'b1;
					end else begin
						sw_fail = 1'b1;
					end
				end
			end
			ST_DWS: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid) begin
					go_duty = 1'b1;
				end
			end
			ST_DDIG: begin
				cmd.scan_run = 1'b1;
				if (sts.ch_valid) begin
					if (sts.c_digit) begin
						cmd.mag_digit = 1'b1;
					end else begin
						cmd.emit     = 1'b1;
						cmd.action   = duty_act;
						cmd.use_duty = 1'b1;
						done         = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// argument starts here: on/off first (not servo), else the percent number; comp without on/off gives no result
		if (go_arg) begin
			if (sts.c_o && (sts.word != sacp_pkg::WORD_SERVO)) begin
				state_d = ST_SW_O;
			end else if (sts.word == sacp_pkg::WORD_COMP) begin
				done = 1'b1;
			end else begin
				go_duty = 1'b1;
			end
		end

		// a failed on/off ends the line: vent gets a percent that starts at the letter o, so zero; comp gets no result
		if (sw_fail) begin
			done = 1'b1;
			if (sts.word != sacp_pkg::WORD_COMP) begin
				cmd.emit     = 1'b1;
				cmd.action   = duty_act;
				cmd.use_duty = 1'b1;
			end
		end

		if (go_duty) begin
			if (sts.c_ws) begin
				state_d = ST_DWS;
			end else if (sts.c_plus) begin
				state_d = ST_DDIG;
			end else if (sts.c_minus) begin
				cmd.set_neg = 1'b1;
				state_d     = ST_DDIG;
			end else if (sts.c_digit) begin
				cmd.mag_digit = 1'b1;
				state_d       = ST_DDIG;
			end else begin
				cmd.emit     = 1'b1;
				cmd.action   = duty_act;
				cmd.use_duty = 1'b1;
				done         = 1'b1;
			end
		end

		if (done) begin
			cmd.clear_len = 1'b1;
			state_d       = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SACP_ASSERT_MSG(a_no_overwrite, clk, arst_n, cmd.emit |-> !out_valid_q, "result overwritten")
	`SACP_ASSERT(a_result_from_scan, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) != ST_IDLE)
	`SACP_ASSERT(a_no_rx_in_scan, clk, arst_n, (state_q != ST_IDLE) |-> !rx_acc)
	`SACP_ASSERT(a_store_not_scan, clk, arst_n, !(cmd.store && cmd.scan_run))

endmodule

`default_nettype wire

@@ design/serial_actuator_command_parser.sv @@
// Serial actuator command parser. Each input item is one received byte; a byte
// that is not CR or LF is stored (up to LINE_BYTES-1 per line, the rest dropped)
// and is taken whenever the parser is idle. A CR or LF that ends a non-empty line
// starts a scan of the line store ram, one character per cycle through its
// registered read port, and the input is held until that scan is done. A line
// end is also held while the previous result has not been taken. Each line gives
// at most one result item: comp on/off, vent on/off or percent, servo percent,
// or an unknown word.
// depends on sacp_pkg, sacp_in_if, sacp_out_if, sacp_ram, sacp_dp and sacp_ctrl
`default_nettype none

module serial_actuator_command_parser #(
	parameter int LINE_BYTES = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sacp_in_if.sink    rx,
	sacp_out_if.source res
);

	sacp_pkg::dp_cmd_t cmd;
	sacp_pkg::dp_sts_t sts;

	sacp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_ready  (rx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sacp_dp #(
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx.rx_byte),
		.cmd         (cmd),
		.sts         (sts),
		.action      (res.action),
		.relay_level (res.relay_level),
		.duty        (res.duty)
	);

endmodule

`default_nettype wire
